>>> rtl/cacs_pkg.sv
// Shared types and codes for the cache-affine CPU selector.
// No dependencies; imported by cache_affine_cpu_selector_unit, cacs_checker and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package cacs_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ACTIVE_CPUS = 2'd0;
  localparam cfg_idx_t REG_INTER_THR   = 2'd1;
  localparam cfg_idx_t REG_BATCH_THR   = 2'd2;

  localparam logic KIND_WAKE   = 1'b0;
  localparam logic KIND_RUN    = 1'b1;
  localparam logic GROUP_BATCH = 1'b1;

  localparam logic [6:0]  ACTIVE_RESET = 7'd64;
  localparam logic [31:0] INTER_RESET  = 32'd10;
  localparam logic [31:0] BATCH_RESET  = 32'd5;

  // starting minimum of the least-load search
  localparam logic [63:0] LOAD_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic       valid;
    logic [5:0] cpu;
  } task_entry_t;

endpackage : cacs_pkg

`default_nettype wire

>>> rtl/cacs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : cacs_ram

`default_nettype wire

>>> rtl/cache_affine_cpu_selector_unit.sv
// Cache-affine CPU selector: top level, sequencer and load/task tables.
// Depends on cacs_pkg and cacs_ram.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+---------------------------
//  input   | in_kind in_task_slot in_group_id in_cpu        | start & !busy
//  result  | out_chosen_cpu out_cache_warm                  | out_valid, one-cycle strobe
//  config  | cfg_index cfg_data                             | cfg_valid & cfg_ready
//
// Running item: written to the task table at accept, busy stays low.
// Wakeup: the last CPU is kept if in range and below threshold, else the least loaded
// of the first n CPUs is searched (n = active CPUs clamped to CPUS); then the chosen
// CPU's load is bumped. The load table's single read port is scanned one counter per cycle.
// Result strobe follows the last busy cycle.
// Reset: a clearing pass over every task table entry, busy meanwhile.
// Results are not stalled; config is always ready.
`timescale 1ns / 1ps
`default_nettype none

module cache_affine_cpu_selector_unit #(
  parameter int CPUS      = 64,
  parameter int TASKS     = 1024,
  parameter int LOAD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_kind,
  input  wire logic [9:0]         in_task_slot,
  input  wire logic               in_group_id,
  input  wire logic [5:0]         in_cpu,
  output logic                    out_valid,
  output logic [5:0]              out_chosen_cpu,
  output logic                    out_cache_warm,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire cacs_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]        cfg_data
);

  import cacs_pkg::*;

  localparam int CA = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int NW = $clog2(CPUS + 1);
  localparam int TA = $clog2(TASKS);
  localparam int EW = $bits(task_entry_t);
  localparam logic [8:0]           CPUS9    = 9'(CPUS);
  localparam logic [TA-1:0]        TASK_END = TA'(TASKS - 1);
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_TRD  = 3'd2;
  localparam logic [2:0] S_LRD  = 3'd3;
  localparam logic [2:0] S_WCHK = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_BRD  = 3'd6;
  localparam logic [2:0] S_BWR  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [TA-1:0] clr_idx_r, clr_idx_nxt;
  logic [6:0]  active_r;
  logic [31:0] inter_thr_r, batch_thr_r;
  logic [CPUS-1:0] lvalid_r, lvalid_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [TA-1:0] slot_r, slot_nxt;
  logic        slot_ok_r, slot_ok_nxt;
  logic        group_r, group_nxt;
  logic        cand_r, cand_nxt;
  logic [5:0]  last_r, last_nxt;
  logic        warm_r, warm_nxt;
  logic [CA-1:0] chosen_r, chosen_nxt;
  logic [NW-1:0] issue_idx_r, issue_idx_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [CA-1:0] rd_idx_r, rd_idx_nxt;
  logic [63:0] lowest_r, lowest_nxt;
  logic [CA-1:0] best_r, best_nxt;
  logic        lv_q_r;
  logic [5:0]  out_cpu_r, out_cpu_nxt;
  logic        out_warm_r, out_warm_nxt;

  logic        accept, slot_ok_in;
  logic [8:0]  n9;
  logic        tram_we;
  logic [TA-1:0] tram_waddr;
  task_entry_t tram_wdata, task_q;
  logic [EW-1:0] tram_q;
  logic        lram_we;
  logic [CA-1:0] lram_raddr;
  logic [LOAD_BITS-1:0] lram_wdata, lram_q, eff_load;
  logic [31:0] limit;

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = start && !busy;
  assign slot_ok_in = (17'(in_task_slot) < 17'(TASKS));
  assign n9         = (9'(active_r) > CPUS9) ? CPUS9 : 9'(active_r);
  assign eff_load   = lv_q_r ? lram_q : '0;
  assign limit      = (group_r == GROUP_BATCH) ? batch_thr_r : inter_thr_r;
  assign task_q     = task_entry_t'(tram_q);

  assign tram_we    = (state_r == S_CLR) ||
                      (accept && in_kind == KIND_RUN && slot_ok_in);
  assign tram_waddr = (state_r == S_CLR) ? clr_idx_r : TA'(in_task_slot);
  always_comb begin
    tram_wdata.valid = (state_r != S_CLR);
    tram_wdata.cpu   = (state_r == S_CLR) ? 6'd0 : in_cpu;
  end

  assign lram_we    = (state_r == S_BWR);
  assign lram_wdata = (eff_load == LOAD_MAX) ? eff_load : eff_load + LOAD_BITS'(1);

  cacs_ram #(.WIDTH(EW), .DEPTH(TASKS)) u_task_ram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tram_waddr),
    .wdata (EW'(tram_wdata)),
    .raddr (slot_r),
    .rdata (tram_q)
  );

  cacs_ram #(.WIDTH(LOAD_BITS), .DEPTH(CPUS)) u_load_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (chosen_r),
    .wdata (lram_wdata),
    .raddr (lram_raddr),
    .rdata (lram_q)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    lvalid_nxt    = lvalid_r;
    out_valid_nxt = 1'b0;
    slot_nxt      = slot_r;
    slot_ok_nxt   = slot_ok_r;
    group_nxt     = group_r;
    cand_nxt      = cand_r;
    last_nxt      = last_r;
    warm_nxt      = warm_r;
    chosen_nxt    = chosen_r;
    issue_idx_nxt = issue_idx_r;
    rd_pend_nxt   = rd_pend_r;
    rd_idx_nxt    = rd_idx_r;
    lowest_nxt    = lowest_r;
    best_nxt      = best_r;
    out_cpu_nxt   = out_cpu_r;
    out_warm_nxt  = out_warm_r;
    lram_raddr    = '0;

    case (state_r)
      S_CLR: begin
        clr_idx_nxt = clr_idx_r + TA'(1);
        if (clr_idx_r == TASK_END) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && in_kind == KIND_WAKE) begin
          slot_nxt    = TA'(in_task_slot);
          slot_ok_nxt = slot_ok_in;
          group_nxt   = in_group_id;
          state_nxt   = S_TRD;
        end
      end
      S_TRD: begin
        state_nxt = S_LRD;
      end
      S_LRD: begin
        last_nxt   = task_q.cpu;
        cand_nxt   = slot_ok_r && task_q.valid && (9'(task_q.cpu) < n9);
        lram_raddr = CA'(task_q.cpu);
        state_nxt  = S_WCHK;
      end
      S_WCHK: begin
        warm_nxt = cand_r && (64'(eff_load) < 64'(limit));
        if (warm_nxt) begin
          chosen_nxt = CA'(last_r);
          state_nxt  = S_BRD;
        end else begin
          issue_idx_nxt = '0;
          rd_pend_nxt   = 1'b0;
          lowest_nxt    = LOAD_NONE;
          best_nxt      = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // one counter read issued, one compared, per cycle
        if (9'(issue_idx_r) < n9) begin
          lram_raddr    = CA'(issue_idx_r);
          rd_pend_nxt   = 1'b1;
          rd_idx_nxt    = CA'(issue_idx_r);
          issue_idx_nxt = issue_idx_r + NW'(1);
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r && (64'(eff_load) < lowest_r)) begin
          lowest_nxt = 64'(eff_load);
          best_nxt   = rd_idx_r;
        end
        if (!rd_pend_r && !(9'(issue_idx_r) < n9)) begin
          chosen_nxt = best_r;
          state_nxt  = S_BRD;
        end
      end
      S_BRD: begin
        lram_raddr = chosen_r;
        state_nxt  = S_BWR;
      end
      S_BWR: begin
        lvalid_nxt[chosen_r] = 1'b1;
        out_valid_nxt = 1'b1;
        out_cpu_nxt   = 6'(chosen_r);
        out_warm_nxt  = warm_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      lvalid_r    <= '0;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RESET;
      inter_thr_r <= INTER_RESET;
      batch_thr_r <= BATCH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      lvalid_r    <= lvalid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_CPUS: active_r    <= cfg_data[6:0];
          REG_INTER_THR:   inter_thr_r <= cfg_data;
          REG_BATCH_THR:   batch_thr_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    slot_ok_r   <= slot_ok_nxt;
    group_r     <= group_nxt;
    cand_r      <= cand_nxt;
    last_r      <= last_nxt;
    warm_r      <= warm_nxt;
    chosen_r    <= chosen_nxt;
    issue_idx_r <= issue_idx_nxt;
    rd_pend_r   <= rd_pend_nxt;
    rd_idx_r    <= rd_idx_nxt;
    lowest_r    <= lowest_nxt;
    best_r      <= best_nxt;
    lv_q_r      <= lvalid_r[lram_raddr];
    out_cpu_r   <= out_cpu_nxt;
    out_warm_r  <= out_warm_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_chosen_cpu = out_cpu_r;
  assign out_cache_warm = out_warm_r;

`ifndef SYNTHESIS
  a_strobe_after_bump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_BWR))
    else $error("result strobe without a load update");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLR && busy))
    else $error("clearing pass did not start after reset");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rd_pend_r) |-> (9'(rd_idx_r) < n9))
    else $error("load scan read beyond active CPUs");

  a_warm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BWR && warm_r) |-> (9'(chosen_r) < n9 && 6'(chosen_r) == last_r))
    else $error("warm choice outside active CPUs");
`endif

endmodule : cache_affine_cpu_selector_unit

`default_nettype wire

>>> verif/cacs_checker.sv
// Scoreboard for the cache-affine CPU selector: tracks per-CPU loads and per-task
// last CPUs, predicts each wakeup's pick and compares it with the result strobe.
// Depends on cacs_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module cacs_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic               in_kind,
  input  wire logic [9:0]         in_task_slot,
  input  wire logic               in_group_id,
  input  wire logic [5:0]         in_cpu,
  input  wire logic               out_valid,
  input  wire logic [5:0]         out_chosen_cpu,
  input  wire logic               out_cache_warm,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire cacs_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      mismatches,
  output int                      picks_pending
);

  import cacs_pkg::*;

  typedef struct packed {
    logic [5:0] cpu;
    logic       warm;
  } cpu_pick_t;

  logic [6:0]  active_cpus_q;
  logic [31:0] inter_thr_q;
  logic [31:0] batch_thr_q;
  logic [31:0] load_q [64];
  logic        slot_valid_q [1024];
  logic [5:0]  slot_cpu_q [1024];
  cpu_pick_t   picks_due [$];

  initial begin
    mismatches    = 0;
    picks_pending = 0;
  end

  // Picks the CPU for a wakeup and bumps its load (saturating).
  function automatic cpu_pick_t pick_cpu(logic [9:0] slot, logic grp);
    int unsigned n;
    logic [31:0] thr;
    logic [63:0] lowest;
    cpu_pick_t   p;
    n = (active_cpus_q > 7'd64) ? 64 : int'(active_cpus_q);
    thr = (grp == GROUP_BATCH) ? batch_thr_q : inter_thr_q;
    p = '0;
    if (slot_valid_q[slot] && slot_cpu_q[slot] < n && load_q[slot_cpu_q[slot]] < thr) begin
      p.cpu  = slot_cpu_q[slot];
      p.warm = 1'b1;
    end else begin
      lowest = LOAD_NONE;
      for (int c = 0; c < n; c++) begin
        if ({32'd0, load_q[c]} < lowest) begin
          lowest = {32'd0, load_q[c]};
          p.cpu  = 6'(c);
        end
      end
    end
    if (load_q[p.cpu] != '1) load_q[p.cpu] = load_q[p.cpu] + 32'd1;
    return p;
  endfunction

  task automatic note_miss(string msg);
    if (mismatches < 10) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cpu_pick_t want;
    if (!rst_n) begin
      active_cpus_q = ACTIVE_RESET;
      inter_thr_q   = INTER_RESET;
      batch_thr_q   = BATCH_RESET;
      foreach (load_q[i]) load_q[i] = '0;
      foreach (slot_valid_q[i]) slot_valid_q[i] = 1'b0;
      picks_due.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (picks_due.size() == 0) begin
          note_miss($sformatf("result with none due: chosen_cpu %0d cache_warm %0b",
                              out_chosen_cpu, out_cache_warm));
        end else begin
          want = picks_due.pop_front();
          if (out_chosen_cpu !== want.cpu || out_cache_warm !== want.warm)
            note_miss($sformatf("chosen_cpu exp %0d got %0d, cache_warm exp %0b got %0b",
                                want.cpu, out_chosen_cpu, want.warm, out_cache_warm));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_CPUS: active_cpus_q = cfg_data[6:0];
          REG_INTER_THR:   inter_thr_q   = cfg_data;
          REG_BATCH_THR:   batch_thr_q   = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_kind == KIND_RUN) begin
          slot_valid_q[in_task_slot] = 1'b1;
          slot_cpu_q[in_task_slot]   = in_cpu;
        end else begin
          picks_due.push_back(pick_cpu(in_task_slot, in_group_id));
        end
      end
    end
    picks_pending = picks_due.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for cache_affine_cpu_selector_unit: clock, reset, directed and
// random wakeup/running items, register phases and the verdict.
// Depends on cacs_pkg, cacs_checker and the block.
`timescale 1ns / 1ps

module tb_top;
  import cacs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = KIND_WAKE;
  logic [9:0]  in_task_slot = '0;
  logic        in_group_id = 1'b0;
  logic [5:0]  in_cpu = '0;
  logic        out_valid;
  logic [5:0]  out_chosen_cpu;
  logic        out_cache_warm;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_ACTIVE_CPUS;
  logic [31:0] cfg_data = '0;

  int          mismatches;
  int          picks_pending;

  logic [6:0]  cur_active;
  int unsigned usable;
  int unsigned idle_odds;
  logic [9:0]  pool_base;
  logic        r_kind;
  logic [9:0]  r_slot;
  logic        r_grp;
  logic [5:0]  r_cpu;

  always #10 clk = ~clk;

  cache_affine_cpu_selector_unit u_top (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_task_slot, .in_group_id, .in_cpu,
    .out_valid, .out_chosen_cpu, .out_cache_warm,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cacs_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_task_slot, .in_group_id, .in_cpu,
    .out_valid, .out_chosen_cpu, .out_cache_warm,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .picks_pending
  );

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic kind, logic [9:0] slot, logic grp, logic [5:0] cpu);
    in_kind      <= kind;
    in_task_slot <= slot;
    in_group_id  <= grp;
    in_cpu       <= cpu;
    start        <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 16)) @(negedge clk);
  endtask

  // all picks back, then room for a search still running after a running item
  task automatic settle_block();
    start <= 1'b0;
    while (picks_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic configure(logic [6:0] act, logic [31:0] ithr, logic [31:0] bthr);
    settle_block();
    write_reg(REG_ACTIVE_CPUS, {25'd0, act});
    write_reg(REG_INTER_THR, ithr);
    write_reg(REG_BATCH_THR, bthr);
    cfg_valid <= 1'b0;
    cur_active = act;
  endtask

  initial begin
    cur_active = ACTIVE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle_block();

    // reset settings: cold picks, warm stays, table overwrite
    send_item(KIND_WAKE, 10'd0,    1'b0, 6'd0);
    send_item(KIND_WAKE, 10'd1023, 1'b1, 6'd63);
    send_item(KIND_RUN,  10'd5,    1'b1, 6'd63);
    send_item(KIND_WAKE, 10'd5,    1'b0, 6'd0);
    send_item(KIND_RUN,  10'd1023, 1'b0, 6'd0);
    send_item(KIND_WAKE, 10'd1023, 1'b1, 6'd0);
    send_item(KIND_RUN,  10'd5,    1'b0, 6'd42);
    send_item(KIND_WAKE, 10'd5,    1'b1, 6'd0);

    // no active CPUs: CPU 0 regardless
    configure(7'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(KIND_WAKE, 10'd5, 1'b1, 6'd0);
    send_item(KIND_WAKE, 10'd3, 1'b0, 6'd0);

    // active count above CPUS is clamped; zero threshold never stays
    configure(7'd127, 32'hFFFF_FFFF, 32'd0);
    send_item(KIND_WAKE, 10'd5, 1'b0, 6'd0);
    send_item(KIND_WAKE, 10'd5, 1'b1, 6'd0);
    send_item(KIND_RUN,  10'd9, 1'b1, 6'd21);
    send_item(KIND_WAKE, 10'd9, 1'b0, 6'd0);

    // last CPU outside the active range
    configure(7'd1, 32'd1, 32'd1);
    send_item(KIND_WAKE, 10'd5,    1'b0, 6'd0);
    send_item(KIND_RUN,  10'd7,    1'b0, 6'd0);
    send_item(KIND_WAKE, 10'd7,    1'b0, 6'd0);
    send_item(KIND_WAKE, 10'd1023, 1'b0, 6'd0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(7'd4, 32'd8, 32'd3);
        1: configure(7'd64, $urandom_range(0, 40), $urandom_range(0, 40));
        2: configure(7'd1, 32'hFFFF_FFFF, 32'd0);
        3: configure(7'($urandom_range(65, 127)), $urandom(), $urandom());
        4: configure(7'($urandom_range(2, 63)), $urandom_range(0, 20), 32'hFFFF_FFFF);
        default: configure(7'd16, $urandom_range(5, 30), $urandom_range(0, 10));
      endcase
      usable    = (cur_active > 7'd64) ? 64 : int'(cur_active);
      pool_base = 10'($urandom_range(0, 1023));
      idle_odds = (ph == 5) ? 0 : $urandom_range(0, 4);
      for (int k = 0; k < 75; k++) begin
        if (ph == 2 && k == 40) settle_block();
        if ($urandom_range(0, 7) < idle_odds) idle_burst();
        r_kind = ($urandom_range(0, 9) < 4) ? KIND_RUN : KIND_WAKE;
        r_slot = ($urandom_range(0, 9) < 8) ? pool_base + 10'($urandom_range(0, 15))
                                             : 10'($urandom_range(0, 1023));
        r_grp  = 1'($urandom_range(0, 1));
        r_cpu  = ($urandom_range(0, 9) < 7 && usable > 0) ? 6'($urandom_range(0, usable - 1))
                                                           : 6'($urandom_range(0, 63));
        send_item(r_kind, r_slot, r_grp, r_cpu);
      end
    end

    settle_block();
    if (mismatches == 0 && picks_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
